>>> rtl/core/socket_slot_table_assert.svh
// Assertion macros for the socket slot table.
// Used at the end of the top level; expects clk_i and rst_ni in scope.
`ifndef SOCKET_SLOT_TABLE_ASSERT_SVH
`define SOCKET_SLOT_TABLE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("socket slot table check failed");

// The consequent holds in the cycle after the antecedent.
`define SST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("socket slot table check failed");

`endif

>>> rtl/core/sst_pkg.sv
// Shared types and constants of the socket slot table.
// Used by the channel interfaces, the slot RAM user and the top level.
`default_nettype none

package sst_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [15:0] EPH_MIN   = 16'd49152;
  localparam logic [15:0] EPH_MAX   = 16'hFFFF;
  localparam logic [14:0] EPH_TRIES = 15'd16384;

  // Request kinds.
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_EPH   = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;
  localparam logic [1:0] KIND_LOOK  = 2'd3;

  // Slot types.
  localparam logic [1:0] TYPE_NONE = 2'd0;
  localparam logic [1:0] TYPE_CONN = 2'd2;
  localparam logic [1:0] TYPE_DGRAM = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_OWNER_ZERO = 3'd1;
  localparam logic [2:0] ST_CAP_FULL   = 3'd2;
  localparam logic [2:0] ST_PORT_LIMIT = 3'd3;
  localparam logic [2:0] ST_NO_SLOT    = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
  localparam logic [2:0] ST_NO_PORT    = 3'd6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 4'd1;

  // One slot as held in the slot RAM.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] port;
    logic [31:0] owner;
    logic [63:0] ident;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

`default_nettype wire

>>> rtl/core/sst_if.sv
// Channel interfaces of the socket slot table: request, response, config.
// Depends on sst_pkg for the configuration index width.
`default_nettype none

interface sst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  socket_type;
  logic [15:0] port;
  logic [31:0] owner;
  logic [63:0] socket_id_in;
  modport source (output valid, kind, socket_type, port, owner, socket_id_in, input ready);
  modport sink   (input valid, kind, socket_type, port, owner, socket_id_in, output ready);
endinterface

interface sst_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] socket_id_out;
  logic [15:0] port_out;
  logic [1:0]  state_out;
  modport source (output valid, status, socket_id_out, port_out, state_out, input ready);
  modport sink   (input valid, status, socket_id_out, port_out, state_out, output ready);
endinterface

interface sst_cfg_if import sst_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [6:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/socket_slot_table.sv
// Socket slot table: SLOTS connection slots held in one RAM, plus an
// ephemeral port allocator. Every request (allocate, allocate ephemeral
// datagram, free, lookup) scans the usable slots, reading one
// slot per cycle from the slot RAM. An ephemeral allocation repeats that
// scan once per candidate port that is in use, up to 16384 scans; one whose
// owner is zero runs no scan and goes straight to the decide state. The
// request side is ready only while no request is in progress; a finished
// response waits in an output register. Slot valid bits reset to free, so
// no clearing pass runs. Configuration writes are always accepted and
// should be made while idle.
`default_nettype none

module socket_slot_table import sst_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sst_req_if.sink   req_i,
  sst_rsp_if.source rsp_o,
  sst_cfg_if.sink   cfg_i
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [1:0]  kind_q, kind_d;
  logic [1:0]  type_q, type_d;
  logic [15:0] port_q, port_d;
  logic [31:0] owner_q, owner_d;
  logic [63:0] id_q, id_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;

  logic [CNT_W-1:0] ccnt_q, ccnt_d;
  logic             free_f_q, free_f_d;
  logic [IDX_W-1:0] free_i_q, free_i_d;
  logic             busy_q, busy_d;
  logic             hit_f_q, hit_f_d;
  logic [IDX_W-1:0] hit_i_q, hit_i_d;
  logic [15:0]      hit_port_q, hit_port_d;
  logic [1:0]       hit_kind_q, hit_kind_d;

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [CNT_W-1:0] open_q, open_d;
  logic [63:0]      next_id_q, next_id_d;
  logic [15:0]      eph_q, eph_d;
  logic [14:0]      tries_q, tries_d;

  logic [6:0] cap_reg_q, cap_reg_d;
  logic [6:0] lim_q, lim_d;

  logic        ov_q, ov_d;
  logic [2:0]  ostat_q, ostat_d;
  logic [63:0] oid_q, oid_d;
  logic [15:0] oport_q, oport_d;
  logic [1:0]  ostate_q, ostate_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  slot_t            ram_wdata, ram_rdata;
  logic [SLOT_W-1:0] rdata_raw;

  logic [CNT_W-1:0] cap;
  logic [15:0]      eph_next;
  logic [63:0]      id_inc;

  // Slot storage.
  sst_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata_raw)
  );
  assign ram_rdata = slot_t'(rdata_raw);

  // Usable slot count, limited to the table size.
  assign cap = (32'(cap_reg_q) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(cap_reg_q);
  assign eph_next = (eph_q == EPH_MAX) ? EPH_MIN : eph_q + 16'd1;
  assign id_inc = next_id_q + 64'd1;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = ov_q;
  assign rsp_o.status = ostat_q;
  assign rsp_o.socket_id_out = oid_q;
  assign rsp_o.port_out = oport_q;
  assign rsp_o.state_out = ostate_q;

  // Sequencer: accept, scan the slots, then decide and respond.
  always_comb begin
    logic start;
    logic alloc_go;
    logic [1:0] a_type;
    logic [15:0] a_port;
    state_d = state_q;
    kind_d = kind_q;
    type_d = type_q;
    port_d = port_q;
    owner_d = owner_q;
    id_d = id_q;
    cnt_d = cnt_q;
    pend_d = 1'b0;
    pidx_d = pidx_q;
    ccnt_d = ccnt_q;
    free_f_d = free_f_q;
    free_i_d = free_i_q;
    busy_d = busy_q;
    hit_f_d = hit_f_q;
    hit_i_d = hit_i_q;
    hit_port_d = hit_port_q;
    hit_kind_d = hit_kind_q;
    valid_d = valid_q;
    open_d = open_q;
    next_id_d = next_id_q;
    eph_d = eph_q;
    tries_d = tries_q;
    cap_reg_d = cap_reg_q;
    lim_d = lim_q;
    ov_d = ov_q;
    ostat_d = ostat_q;
    oid_d = oid_q;
    oport_d = oport_q;
    ostate_d = ostate_q;
    ram_we = 1'b0;
    ram_waddr = free_i_q;
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = cnt_q[IDX_W-1:0];
    start = 1'b0;
    alloc_go = 1'b0;
    a_type = type_q;
    a_port = port_q;

    // Configuration writes.
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SLOTS: cap_reg_d = cfg_i.data;
        CFG_LIMIT: lim_d = cfg_i.data;
        default: ;
      endcase
    end

    // Response transaction taken.
    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d = req_i.kind;
          type_d = req_i.socket_type;
          port_d = req_i.port;
          owner_d = req_i.owner;
          id_d = req_i.socket_id_in;
          if (req_i.kind == KIND_EPH) begin
            if (req_i.owner == 32'd0) begin
              state_d = S_DECIDE;
            end else begin
              port_d = eph_q;
              eph_d = eph_next;
              tries_d = 15'd1;
              start = 1'b1;
            end
          end else begin
            start = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // Evaluate the slot read in the previous cycle.
        if (pend_q) begin
          if (valid_q[pidx_q]) begin
            if (ram_rdata.kind == TYPE_CONN && ram_rdata.port == port_q) begin
              ccnt_d = ccnt_q + CNT_W'(1);
            end
            if (ram_rdata.port == port_q) begin
              busy_d = 1'b1;
            end
            if (!hit_f_q && ram_rdata.ident == id_q && ram_rdata.owner == owner_q) begin
              hit_f_d = 1'b1;
              hit_i_d = pidx_q;
              hit_port_d = ram_rdata.port;
              hit_kind_d = ram_rdata.kind;
            end
          end else if (!free_f_q) begin
            free_f_d = 1'b1;
            free_i_d = pidx_q;
          end
        end
        // Issue the next read.
        if (cnt_q < cap) begin
          ram_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = cnt_q[IDX_W-1:0];
          cnt_d = cnt_q + CNT_W'(1);
        end else if (!pend_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!ov_q || rsp_o.ready) begin
          ostat_d = ST_OK;
          oid_d = '0;
          oport_d = '0;
          ostate_d = '0;
          state_d = S_IDLE;
          case (kind_q)
            KIND_ALLOC: begin
              if (owner_q == 32'd0) begin
                ostat_d = ST_OWNER_ZERO;
              end else if (open_q >= cap) begin
                ostat_d = ST_CAP_FULL;
              end else if (type_q == TYPE_NONE) begin
                ostat_d = ST_NO_SLOT;
              end else if (type_q == TYPE_CONN && 32'(ccnt_q) >= 32'(lim_q)) begin
                ostat_d = ST_PORT_LIMIT;
              end else if (!free_f_q) begin
                ostat_d = ST_NO_SLOT;
              end else begin
                alloc_go = 1'b1;
              end
            end
            KIND_EPH: begin
              a_type = TYPE_DGRAM;
              if (owner_q == 32'd0) begin
                ostat_d = ST_OWNER_ZERO;
              end else if (busy_q) begin
                if (tries_q == EPH_TRIES) begin
                  ostat_d = ST_NO_PORT;
                end else begin
                  // Try the next candidate port.
                  port_d = eph_q;
                  eph_d = eph_next;
                  tries_d = tries_q + 15'd1;
                  start = 1'b1;
                end
              end else if (open_q >= cap) begin
                ostat_d = ST_CAP_FULL;
              end else if (!free_f_q) begin
                ostat_d = ST_NO_SLOT;
              end else begin
                alloc_go = 1'b1;
                oport_d = port_q;
              end
            end
            KIND_FREE: begin
              if (!hit_f_q) begin
                ostat_d = ST_NOT_FOUND;
              end else begin
                valid_d[hit_i_q] = 1'b0;
                if (open_q != '0) begin
                  open_d = open_q - CNT_W'(1);
                end
              end
            end
            KIND_LOOK: begin
              if (!hit_f_q) begin
                ostat_d = ST_NOT_FOUND;
              end else begin
                oport_d = hit_port_q;
                ostate_d = hit_kind_q;
              end
            end
            default: ;
          endcase
          if (alloc_go) begin
            ram_we = 1'b1;
            ram_wdata.kind = a_type;
            ram_wdata.port = a_port;
            ram_wdata.owner = owner_q;
            ram_wdata.ident = next_id_q;
            valid_d[free_i_q] = 1'b1;
            open_d = open_q + CNT_W'(1);
            oid_d = next_id_q;
            next_id_d = (id_inc == 64'd0) ? 64'd1 : id_inc;
          end
          if (!start) begin
            ov_d = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Begin a scan pass over the usable slots.
    if (start) begin
      state_d = S_SCAN;
      cnt_d = '0;
      pend_d = 1'b0;
      ccnt_d = '0;
      free_f_d = 1'b0;
      busy_d = 1'b0;
      hit_f_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q <= 1'b0;
      cnt_q <= '0;
      valid_q <= '0;
      open_q <= '0;
      next_id_q <= 64'd1;
      eph_q <= EPH_MIN;
      tries_q <= '0;
      cap_reg_q <= 7'd64;
      lim_q <= 7'd8;
      ov_q <= 1'b0;
      free_f_q <= 1'b0;
      busy_q <= 1'b0;
      hit_f_q <= 1'b0;
      ccnt_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q <= pend_d;
      cnt_q <= cnt_d;
      valid_q <= valid_d;
      open_q <= open_d;
      next_id_q <= next_id_d;
      eph_q <= eph_d;
      tries_q <= tries_d;
      cap_reg_q <= cap_reg_d;
      lim_q <= lim_d;
      ov_q <= ov_d;
      free_f_q <= free_f_d;
      busy_q <= busy_d;
      hit_f_q <= hit_f_d;
      ccnt_q <= ccnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    type_q <= type_d;
    port_q <= port_d;
    owner_q <= owner_d;
    id_q <= id_d;
    pidx_q <= pidx_d;
    free_i_q <= free_i_d;
    hit_i_q <= hit_i_d;
    hit_port_q <= hit_port_d;
    hit_kind_q <= hit_kind_d;
    ostat_q <= ostat_d;
    oid_q <= oid_d;
    oport_q <= oport_d;
    ostate_q <= ostate_d;
  end

  `include "socket_slot_table_assert.svh"

  `SST_ASSERT_NOW(a_open_bound, 1'b1, 32'(open_q) <= SLOTS)
  `SST_ASSERT_NOW(a_id_nonzero, 1'b1, next_id_q != 64'd0)
  `SST_ASSERT_NOW(a_eph_range, 1'b1, eph_q >= EPH_MIN)
  `SST_ASSERT_NEXT(a_scan_ends, state_q == S_SCAN && cnt_q >= cap && !pend_q, state_q == S_DECIDE)

endmodule

`default_nettype wire

>>> tb/tb_socket_slot_table.sv
// Self-checking testbench for the socket slot table.
// Depends on sst_pkg, the channel interfaces in sst_if.sv and the top level.
`timescale 1ns / 100ps

module tb_socket_slot_table;
  import sst_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  stype;
    logic [15:0] port;
    logic [31:0] owner;
    logic [63:0] ident;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] ident;
    logic [15:0] port;
    logic [1:0]  state;
  } answer_t;

  // Slot table mirror: predicts every answer and checks the ones observed.
  class slot_table_sb;
    logic [1:0]  kind_m[SLOTS];
    logic [15:0] port_m[SLOTS];
    logic [31:0] owner_m[SLOTS];
    logic [63:0] ident_m[SLOTS];
    logic [63:0] next_ident;
    logic [15:0] next_eph;
    int          open_cnt;
    int          cap_reg;
    int          limit_reg;
    answer_t     pending_q[$];
    int          errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        kind_m[i] = TYPE_NONE;
        port_m[i] = '0;
        owner_m[i] = '0;
        ident_m[i] = '0;
      end
      next_ident = 64'd1;
      next_eph = EPH_MIN;
      open_cnt = 0;
      cap_reg = 64;
      limit_reg = 8;
      errors = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [6:0] value);
      if (idx == CFG_SLOTS) cap_reg = int'(value);
      else if (idx == CFG_LIMIT) limit_reg = int'(value);
    endfunction

    function int usable();
      return (cap_reg > SLOTS) ? SLOTS : cap_reg;
    endfunction

    function logic [2:0] place(logic [1:0] stype, logic [15:0] port,
                               logic [31:0] owner, output logic [63:0] ident);
      int n;
      n = 0;
      ident = '0;
      if (owner == '0) return ST_OWNER_ZERO;
      if (open_cnt >= usable()) return ST_CAP_FULL;
      if (stype == TYPE_NONE) return ST_NO_SLOT;
      if (stype == TYPE_CONN) begin
        for (int i = 0; i < usable(); i++)
          if (kind_m[i] == TYPE_CONN && port_m[i] == port) n++;
        if (n >= limit_reg) return ST_PORT_LIMIT;
      end
      for (int i = 0; i < usable(); i++) begin
        if (kind_m[i] == TYPE_NONE) begin
          kind_m[i] = stype;
          port_m[i] = port;
          owner_m[i] = owner;
          ident_m[i] = next_ident;
          open_cnt++;
          ident = next_ident;
          next_ident++;
          if (next_ident == '0) next_ident = 64'd1;
          return ST_OK;
        end
      end
      return ST_NO_SLOT;
    endfunction

    function bit port_taken(logic [15:0] port);
      for (int i = 0; i < usable(); i++)
        if (kind_m[i] != TYPE_NONE && port_m[i] == port) return 1'b1;
      return 1'b0;
    endfunction

    function int locate(logic [63:0] ident, logic [31:0] owner);
      for (int i = 0; i < usable(); i++)
        if (kind_m[i] != TYPE_NONE && ident_m[i] == ident && owner_m[i] == owner)
          return i;
      return -1;
    endfunction

    // Runs one accepted request through the mirror and queues its answer.
    function void note_request(request_t r);
      answer_t     a;
      logic [15:0] cand;
      int          s;
      a = '0;
      case (r.kind)
        KIND_ALLOC: a.status = place(r.stype, r.port, r.owner, a.ident);
        KIND_EPH: begin
          if (r.owner == '0) begin
            a.status = ST_OWNER_ZERO;
          end else begin
            a.status = ST_NO_PORT;
            for (int t = 0; t < EPH_TRIES; t++) begin
              cand = next_eph;
              next_eph = (cand == EPH_MAX) ? EPH_MIN : cand + 16'd1;
              if (port_taken(cand)) continue;
              a.status = place(TYPE_DGRAM, cand, r.owner, a.ident);
              if (a.status == ST_OK) a.port = cand;
              break;
            end
          end
        end
        KIND_FREE: begin
          s = locate(r.ident, r.owner);
          if (s < 0) begin
            a.status = ST_NOT_FOUND;
          end else begin
            kind_m[s] = TYPE_NONE;
            port_m[s] = '0;
            owner_m[s] = '0;
            ident_m[s] = '0;
            if (open_cnt > 0) open_cnt--;
            a.status = ST_OK;
          end
        end
        default: begin
          s = locate(r.ident, r.owner);
          if (s < 0) begin
            a.status = ST_NOT_FOUND;
          end else begin
            a.status = ST_OK;
            a.port = port_m[s];
            a.state = kind_m[s];
          end
        end
      endcase
      pending_q.push_back(a);
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response: %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("response mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sst_req_if req_if ();
  sst_rsp_if rsp_if ();
  sst_cfg_if cfg_if ();

  socket_slot_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  slot_table_sb sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_responses;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("tb_socket_slot_table: errors");
    $finish;
  end

  // Response side: checks every transaction and picks ready at random, except while hold_responses holds it low.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_answer({rsp_if.status, rsp_if.socket_id_out, rsp_if.port_out,
                         rsp_if.state_out});
      if (hold_responses) begin
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_responses = 1'b0;
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_request(request_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_if.kind <= r.kind;
    req_if.socket_type <= r.stype;
    req_if.port <= r.port;
    req_if.owner <= r.owner;
    req_if.socket_id_in <= r.ident;
    req_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(r);
  endtask

  // Registers change only once every outstanding answer has come back.
  task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [6:0] value);
    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_if.index <= idx;
    cfg_if.data <= value;
    cfg_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    sb.configure(idx, value);
  endtask

  function automatic request_t make_request(logic [1:0] kind, logic [1:0] stype,
                                            logic [15:0] port, logic [31:0] owner,
                                            logic [63:0] ident);
    request_t r;
    r.kind = kind;
    r.stype = stype;
    r.port = port;
    r.owner = owner;
    r.ident = ident;
    return r;
  endfunction

  // Random request, biased toward live slots so free and lookup often hit.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       roll;
    roll = $urandom_range(0, 99);
    r.kind = (roll < 35) ? KIND_ALLOC : (roll < 55) ? KIND_EPH :
             (roll < 85) ? KIND_FREE : KIND_LOOK;
    r.stype = 2'($urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    if (roll < 40) r.port = (roll % 4 == 0) ? 16'd0 : (roll % 4 == 1) ? 16'd80 :
                            (roll % 4 == 2) ? 16'd443 : 16'd1024;
    else if (roll < 50) r.port = 16'($urandom);
    else r.port = 16'($urandom_range(1, 49151));
    roll = $urandom_range(0, 99);
    r.owner = (roll < 5) ? 32'd0 : (roll < 65) ? $urandom_range(1, 4) : $urandom;
    r.ident = {$urandom, $urandom};
    if ((r.kind == KIND_FREE || r.kind == KIND_LOOK) && $urandom_range(0, 99) < 70) begin
      pick = $urandom_range(0, SLOTS - 1);
      if (sb.kind_m[pick] != TYPE_NONE) begin
        r.ident = sb.ident_m[pick];
        if ($urandom_range(0, 9) != 0) r.owner = sb.owner_m[pick];
      end
    end
    return r;
  endfunction

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      case ((n / 75) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      send_request(random_request());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    hold_responses = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    req_if.valid = 1'b0;
    req_if.kind = KIND_ALLOC;
    req_if.socket_type = TYPE_NONE;
    req_if.port = '0;
    req_if.owner = '0;
    req_if.socket_id_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SLOTS;
    cfg_if.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: field extremes, every kind and the refusal cases other than running out of ephemeral ports.
    write_config(CFG_SLOTS, 7'd64);
    write_config(CFG_LIMIT, 7'd2);
    send_request(make_request(KIND_ALLOC, 2'd1, 16'd0, 32'd0, '0));
    send_request(make_request(KIND_ALLOC, TYPE_NONE, 16'd5, 32'd1, '0));
    send_request(make_request(KIND_ALLOC, 2'd1, 16'd0, 32'd1, '1));
    send_request(make_request(KIND_ALLOC, TYPE_CONN, 16'hFFFF, 32'hFFFFFFFF, '0));
    send_request(make_request(KIND_ALLOC, TYPE_CONN, 16'hFFFF, 32'd2, '0));
    send_request(make_request(KIND_ALLOC, TYPE_CONN, 16'hFFFF, 32'd3, '0));
    send_request(make_request(KIND_ALLOC, TYPE_DGRAM, 16'd49152, 32'd4, '0));
    send_request(make_request(KIND_EPH, 2'd0, 16'd0, 32'd0, '0));
    send_request(make_request(KIND_EPH, 2'd1, 16'hFFFF, 32'd5, '1));
    send_request(make_request(KIND_EPH, 2'd2, 16'd7, 32'd5, '0));
    send_request(make_request(KIND_LOOK, 2'd3, 16'd9, 32'hFFFFFFFF, 64'd2));
    send_request(make_request(KIND_LOOK, 2'd0, 16'd0, 32'd1, 64'd2));
    send_request(make_request(KIND_LOOK, 2'd0, 16'd0, 32'd1, '1));
    send_request(make_request(KIND_FREE, 2'd0, 16'd0, 32'd9, 64'd1));
    send_request(make_request(KIND_FREE, 2'd1, 16'hFFFF, 32'd1, 64'd1));
    send_request(make_request(KIND_LOOK, 2'd0, 16'd0, 32'd1, 64'd1));
    send_request(make_request(KIND_FREE, 2'd0, 16'd0, 32'd0, '0));
    write_config(CFG_LIMIT, 7'd0);
    send_request(make_request(KIND_ALLOC, TYPE_CONN, 16'd80, 32'd1, '0));
    write_config(CFG_SLOTS, 7'd1);
    send_request(make_request(KIND_ALLOC, 2'd1, 16'd80, 32'd1, '0));
    send_request(make_request(KIND_LOOK, 2'd0, 16'd0, 32'd4, 64'd5));

    // Random phases across several register settings.
    write_config(CFG_SLOTS, 7'd64);
    write_config(CFG_LIMIT, 7'd8);
    hold_responses = 1'b1;
    run_random(300);
    write_config(CFG_SLOTS, 7'd1);
    write_config(CFG_LIMIT, 7'd1);
    run_random(200);
    write_config(CFG_SLOTS, 7'd0);
    write_config(CFG_LIMIT, 7'd0);
    run_random(100);
    write_config(CFG_SLOTS, 7'd127);
    write_config(CFG_LIMIT, 7'd127);
    run_random(300);
    write_config(CFG_SLOTS, 7'd4);
    write_config(CFG_LIMIT, 7'd2);
    run_random(300);
    write_config(CFG_SLOTS, 7'd64);
    write_config(CFG_LIMIT, 7'd1);
    run_random(300);
    write_config(CFG_SLOTS, 7'd2);
    write_config(CFG_LIMIT, 7'd64);
    run_random(300);

    // Drain all outstanding answers, then allow for the scan latency.
    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_socket_slot_table: clean");
    end else begin
      $display("tb_socket_slot_table: errors");
    end
    $finish;
  end
endmodule
